[sv/iapp_pkg.sv]
// ----------------------------------------------------------------------------
// iapp_pkg
// Shared types, constants and the degree scaling for the angle packet parser.
// ----------------------------------------------------------------------------
`default_nettype none

package iapp_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned WORD_W    = 16;
  localparam int unsigned POS_W     = 4;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned OUT_W     = 4 * WORD_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PACKET_TYPE = 8'd1;

  localparam logic [BYTE_W-1:0] HEADER_BYTE_RST = 8'h55;
  localparam logic [BYTE_W-1:0] PACKET_TYPE_RST = 8'h53;

  // packet byte positions
  localparam logic [POS_W-1:0] POS_TYPE    = 4'd1;
  localparam logic [POS_W-1:0] POS_ROLL_LO = 4'd2;
  localparam logic [POS_W-1:0] POS_ROLL_HI = 4'd3;
  localparam logic [POS_W-1:0] POS_PTCH_LO = 4'd4;
  localparam logic [POS_W-1:0] POS_PTCH_HI = 4'd5;
  localparam logic [POS_W-1:0] POS_CHKSUM  = 4'd10;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_TYPE   = 3'b010,
    PH_DATA   = 3'b100
  } phase_t;

  typedef struct packed {
    logic              vld;
    logic [WORD_W-1:0] roll;
    logic [WORD_W-1:0] pitch;
  } pkt_t;

  // floor(code * 45 / 64): code*180/32768 degrees in Q9.7
  function automatic logic [WORD_W-1:0] to_deg_q7(input logic [WORD_W-1:0] code);
    logic [WORD_W+5:0] prod;
    prod = {1'b0, code, 5'b0} + {3'b0, code, 3'b0} + {4'b0, code, 2'b0} + {6'b0, code};
    return prod[WORD_W+5:6];
  endfunction

endpackage

`default_nettype wire

[sv/iapp_parse.sv]
// ----------------------------------------------------------------------------
// iapp_parse
// Input byte register and packet framing state: header, type, data, checksum.
// ----------------------------------------------------------------------------
`default_nettype none

module iapp_parse (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [iapp_pkg::BYTE_W-1:0]  in_tdata,   // [7:0] rx_byte
  input  wire logic [iapp_pkg::BYTE_W-1:0]  header_byte,
  input  wire logic [iapp_pkg::BYTE_W-1:0]  packet_type,
  input  wire logic                         take_i,
  output iapp_pkg::pkt_t                    pkt_o
);

  logic                         in_vld_r, in_vld_nxt;
  logic [iapp_pkg::BYTE_W-1:0]  byte_r, byte_nxt;
  iapp_pkg::phase_t             ph_r, ph_nxt;
  logic [iapp_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic [iapp_pkg::BYTE_W-1:0]  sum_r, sum_nxt;
  logic [iapp_pkg::WORD_W-1:0]  roll_r, roll_nxt;
  logic [iapp_pkg::WORD_W-1:0]  pitch_r, pitch_nxt;
  logic                         cons;

  assign in_tready = !in_vld_r || take_i;
  assign cons      = in_vld_r && take_i;

  always_comb begin
    in_vld_nxt = in_tready ? in_tvalid : in_vld_r;
    byte_nxt   = (in_tvalid && in_tready) ? in_tdata : byte_r;
    ph_nxt     = ph_r;
    pos_nxt    = pos_r;
    sum_nxt    = sum_r;
    roll_nxt   = roll_r;
    pitch_nxt  = pitch_r;
    pkt_o.vld   = 1'b0;
    pkt_o.roll  = roll_r;
    pkt_o.pitch = pitch_r;
    if (cons) begin
      case (ph_r)
        iapp_pkg::PH_TYPE: begin
          if (byte_r == packet_type) begin
            sum_nxt = sum_r + byte_r;
            ph_nxt  = iapp_pkg::PH_DATA;
            pos_nxt = iapp_pkg::POS_ROLL_LO;
          end
        end
        iapp_pkg::PH_DATA: begin
          if (pos_r >= iapp_pkg::POS_ROLL_LO && pos_r < iapp_pkg::POS_CHKSUM) begin
            case (pos_r)
              iapp_pkg::POS_ROLL_LO: roll_nxt  = {roll_r[15:8], byte_r};
              iapp_pkg::POS_ROLL_HI: roll_nxt  = {byte_r, roll_r[7:0]};
              iapp_pkg::POS_PTCH_LO: pitch_nxt = {pitch_r[15:8], byte_r};
              iapp_pkg::POS_PTCH_HI: pitch_nxt = {byte_r, pitch_r[7:0]};
              default: ;
            endcase
            sum_nxt = sum_r + byte_r;
            pos_nxt = pos_r + 4'd1;
          end else begin
            ph_nxt    = iapp_pkg::PH_HEADER;
            pos_nxt   = '0;
            pkt_o.vld = (byte_r == sum_r);
          end
        end
        default: begin
          ph_nxt = iapp_pkg::PH_HEADER;
          if (byte_r == header_byte) begin
            sum_nxt = byte_r;
            ph_nxt  = iapp_pkg::PH_TYPE;
            pos_nxt = iapp_pkg::POS_TYPE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      ph_r     <= iapp_pkg::PH_HEADER;
      pos_r    <= '0;
      sum_r    <= '0;
    end else begin
      in_vld_r <= in_vld_nxt;
      ph_r     <= ph_nxt;
      pos_r    <= pos_nxt;
      sum_r    <= sum_nxt;
    end
    byte_r  <= byte_nxt;
    roll_r  <= roll_nxt;
    pitch_r <= pitch_nxt;
  end

  a_pkt_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    pkt_o.vld |-> take_i && in_vld_r)
    else $error("packet completed without room in the result register");

  a_pos_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    ph_r == iapp_pkg::PH_DATA |-> pos_r >= iapp_pkg::POS_ROLL_LO &&
                                  pos_r <= iapp_pkg::POS_CHKSUM)
    else $error("byte position out of range while collecting data");

  a_chksum_ends: assert property (@(posedge clk) disable iff (!rst_n)
    cons && ph_r == iapp_pkg::PH_DATA && pos_r == iapp_pkg::POS_CHKSUM
    |=> ph_r == iapp_pkg::PH_HEADER)
    else $error("checksum byte did not return to header search");

endmodule

`default_nettype wire

[sv/iapp_out.sv]
// ----------------------------------------------------------------------------
// iapp_out
// Degree scaling and result register of the angle packet parser.
// ----------------------------------------------------------------------------
`default_nettype none

module iapp_out (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire iapp_pkg::pkt_t               pkt_i,
  output logic                              take_o,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [iapp_pkg::OUT_W-1:0]        out_tdata
);

  logic                         out_vld_r, out_vld_nxt;
  logic [iapp_pkg::OUT_W-1:0]   data_r, data_nxt;

  assign take_o     = !out_vld_r || out_tready;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = data_r;

  always_comb begin
    out_vld_nxt = out_vld_r && !out_tready;
    data_nxt    = data_r;
    if (pkt_i.vld) begin
      out_vld_nxt = 1'b1;
      data_nxt    = {iapp_pkg::to_deg_q7(pkt_i.pitch), iapp_pkg::to_deg_q7(pkt_i.roll),
                     pkt_i.pitch, pkt_i.roll};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
    data_r <= data_nxt;
  end

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    pkt_i.vld |=> out_tvalid)
    else $error("completed packet not presented");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_tready |-> !pkt_i.vld)
    else $error("pending result overwritten");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_tready |=> out_vld_r && $stable(data_r))
    else $error("stalled result changed");

endmodule

`default_nettype wire

[sv/imu_angle_packet_parser_unit.sv]
// ----------------------------------------------------------------------------
// imu_angle_packet_parser_unit
// Finds 11-byte angle packets in a serial byte stream and reports roll/pitch.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one received byte per transfer (in_tdata[7:0]).
//   out_* : one transfer per packet whose additive checksum matches:
//           roll code, pitch code and both in degrees, unsigned Q9.7.
//   cfg_* : write header byte (index 0) and packet type (index 1);
//           cfg_ready is always high. Write only while the stream is idle.
// Timing:
//   A byte is parsed from the input register once the result side can take;
//   the result of a checksum byte goes through the result register to out_tvalid.
//   One byte per cycle is sustained while the result side drains.
// Reset (rst_n low, synchronous): parser returns to header search, both
//   registers to 0x55 / 0x53, and no result is pending.
// Stall: while a result waits on out_tready the byte in the input register
//   holds; an empty input register still takes one byte, then in_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_angle_packet_parser_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [iapp_pkg::BYTE_W-1:0]    in_tdata,   // [7:0] rx_byte
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // [15:0] roll_code, [31:16] pitch_code, [47:32] roll_deg_q7, [63:48] pitch_deg_q7
  output logic [iapp_pkg::OUT_W-1:0]          out_tdata,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [iapp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [iapp_pkg::BYTE_W-1:0]    cfg_data
);

  logic [iapp_pkg::BYTE_W-1:0] header_byte_r, header_byte_nxt;
  logic [iapp_pkg::BYTE_W-1:0] packet_type_r, packet_type_nxt;
  logic                        take;
  iapp_pkg::pkt_t              pkt;

  assign cfg_ready = 1'b1;

  always_comb begin
    header_byte_nxt = header_byte_r;
    packet_type_nxt = packet_type_r;
    if (cfg_valid) begin
      case (cfg_index)
        iapp_pkg::REG_HEADER_BYTE: header_byte_nxt = cfg_data;
        iapp_pkg::REG_PACKET_TYPE: packet_type_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_byte_r <= iapp_pkg::HEADER_BYTE_RST;
      packet_type_r <= iapp_pkg::PACKET_TYPE_RST;
    end else begin
      header_byte_r <= header_byte_nxt;
      packet_type_r <= packet_type_nxt;
    end
  end

  iapp_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .header_byte (header_byte_r),
    .packet_type (packet_type_r),
    .take_i      (take),
    .pkt_o       (pkt)
  );

  iapp_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .pkt_i      (pkt),
    .take_o     (take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire
